### sv/counter_time_slice_scheduler_unit_defines.svh
// Assertion helpers for the time-slice scheduler.
`ifndef COUNTER_TIME_SLICE_SCHEDULER_UNIT_DEFINES_SVH
`define COUNTER_TIME_SLICE_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CTSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);
`else
`define CTSU_ASSERT(lbl, prop, msg)
`define CTSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/ctsu_pkg.sv
package ctsu_pkg;

    localparam logic [2:0] OP_DEFINE  = 3'd0;
    localparam logic [2:0] OP_ENQUEUE = 3'd1;
    localparam logic [2:0] OP_DEQUEUE = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_PICK    = 3'd4;

    localparam logic [7:0] BASE_SLICE_RESET = 8'd5;

    // One slot of the task table.
    typedef struct packed {
        logic       queued;
        logic [3:0] recency;
        logic [7:0] prio;
        logic [8:0] counter;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        SW_SCAN,
        SW_REFILL,
        SW_ENQ,
        SW_DEQ
    } t_sweep;

endpackage

### sv/ctsu_table.sv
module ctsu_table
    import ctsu_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry             mem [DEPTH];
    t_entry             r_rd_data;
    logic [DEPTH-1:0]   r_written;
    logic               r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= mem[i_raddr];
    end

    // Per-entry written flags: an entry never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_rd_written <= r_written[i_raddr];
        end
    end

    assign o_rdata = r_rd_written ? r_rd_data : '0;

endmodule

### sv/counter_time_slice_scheduler_unit.sv
// Task scheduler over MAX_TASKS slots kept in one synchronous table. An item is taken when
// start is high and busy is low; its single result appears for one cycle with o_done, and
// the receiver cannot stall it. Unknown operations go straight to the result. Define, tick
// and repeated enqueue/dequeue read the slot, check it and finish; a real enqueue or dequeue
// then sweeps all slots to update the recency ranks. Pick scans all slots, or, when the best
// counter is spent, scans, refills spent counters in a further sweep and scans again. busy
// falls at the end of the o_done cycle. With the single table read port every sweep visits
// one slot per cycle. The base slice is written through i_cfg_we/i_cfg_wdata; it must be
// written only while the block is idle, which the block itself does not enforce.
`include "counter_time_slice_scheduler_unit_defines.svh"

module counter_time_slice_scheduler_unit
    import ctsu_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    output logic       o_done,
    input  logic [2:0] i_operation,
    input  logic [3:0] i_task_req,
    input  logic [7:0] i_priority_req,
    input  logic [8:0] i_initial_slice,
    output logic [3:0] o_chosen_task,
    output logic       o_chosen_valid,
    output logic       o_refilled,
    output logic       o_resched,
    output logic [8:0] o_slice_now,
    output logic [4:0] o_queued_count,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] IDX_END   = CW'(MAX_TASKS);

    t_state         r_state, n_state;
    logic [2:0]     r_op;
    logic [AW-1:0]  r_t;
    logic [7:0]     r_prio_in;
    logic [8:0]     r_slice_in;
    t_sweep         r_mode;
    logic [CW-1:0]  r_idx;
    logic           r_pv;
    logic [AW-1:0]  r_pidx;
    logic [3:0]     r_rec_t;
    logic           r_found;
    logic [AW-1:0]  r_best_idx;
    logic [8:0]     r_best_cnt;
    logic [3:0]     r_best_rec;
    logic           r_refilled;
    logic [4:0]     r_qtotal;
    logic [7:0]     r_def;
    logic [3:0]     r_chosen;
    logic           r_cvalid;
    logic           r_rsched;
    logic [8:0]     r_slice_out;

    t_entry         rd;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [AW-1:0]  mem_raddr;
    t_entry         mem_wdata;

    logic           req_ok;
    logic           sweep_end;
    logic           better;
    logic           scan_found;
    logic [AW-1:0]  scan_idx;
    logic [8:0]     scan_cnt;
    logic [3:0]     scan_rec;
    logic           refill_go;
    logic [8:0]     tick_cnt;

    ctsu_table #(
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign req_ok    = 8'(i_task_req) < 8'(MAX_TASKS);
    assign sweep_end = (r_state == ST_SWEEP) && r_pv && (r_pidx == LAST_SLOT);
    assign tick_cnt  = (rd.counter <= 9'd1) ? 9'd0 : rd.counter - 9'd1;

    // Best queued slot so far: larger counter wins, ties to the lower recency rank.
    assign better = r_pv && rd.queued &&
                    (!r_found || (rd.counter > r_best_cnt) ||
                     ((rd.counter == r_best_cnt) && (rd.recency < r_best_rec)));
    assign scan_found = r_found || better;
    assign scan_idx   = better ? r_pidx : r_best_idx;
    assign scan_cnt   = better ? rd.counter : r_best_cnt;
    assign scan_rec   = better ? rd.recency : r_best_rec;
    assign refill_go  = sweep_end && (r_mode == SW_SCAN) && scan_found &&
                        (scan_cnt == 9'd0) && !r_refilled;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if ((i_operation <= OP_TICK) && req_ok) begin
                        n_state = ST_READ;
                    end else if (i_operation == OP_PICK) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                case (r_op)
                    OP_ENQUEUE: n_state = rd.queued ? ST_FINISH : ST_SWEEP;
                    OP_DEQUEUE: n_state = rd.queued ? ST_SWEEP : ST_FINISH;
                    default:    n_state = ST_FINISH;
                endcase
            end
            ST_SWEEP: begin
                if (sweep_end && !refill_go && (r_mode != SW_REFILL)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy      = (r_state != ST_IDLE);
        o_done    = (r_state == ST_FINISH);
        mem_raddr = (r_state == ST_READ) ? r_t : r_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_t;
        mem_wdata = rd;
        case (r_state)
            ST_CHECK: begin
                if (r_op == OP_DEFINE) begin
                    mem_we            = 1'b1;
                    mem_wdata.prio    = r_prio_in;
                    mem_wdata.counter = r_slice_in;
                end else if (r_op == OP_TICK) begin
                    mem_we            = 1'b1;
                    mem_wdata.counter = tick_cnt;
                end
            end
            ST_SWEEP: begin
                mem_waddr = r_pidx;
                case (r_mode)
                    SW_ENQ: begin
                        mem_we = r_pv;
                        if (r_pidx == r_t) begin
                            mem_wdata.queued  = 1'b1;
                            mem_wdata.recency = 4'd0;
                        end else if (rd.queued) begin
                            mem_wdata.recency = rd.recency + 4'd1;
                        end
                    end
                    SW_DEQ: begin
                        mem_we = r_pv;
                        if (r_pidx == r_t) begin
                            mem_wdata.queued  = 1'b0;
                            mem_wdata.recency = 4'd0;
                        end else if (rd.queued && (rd.recency > r_rec_t)) begin
                            mem_wdata.recency = rd.recency - 4'd1;
                        end
                    end
                    SW_REFILL: begin
                        mem_we = r_pv && (rd.counter == 9'd0);
                        mem_wdata.counter = 9'(r_def) + 9'(rd.prio);
                    end
                    default: begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pv     <= 1'b0;
            r_qtotal <= '0;
            r_def    <= BASE_SLICE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_def <= i_cfg_wdata;
            end
            if ((r_state == ST_SWEEP) && !sweep_end) begin
                r_pv <= (r_idx != IDX_END);
            end else begin
                r_pv <= 1'b0;
            end
            if (r_state == ST_CHECK) begin
                if ((r_op == OP_ENQUEUE) && !rd.queued) begin
                    r_qtotal <= r_qtotal + 5'd1;
                end else if ((r_op == OP_DEQUEUE) && rd.queued) begin
                    r_qtotal <= r_qtotal - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_op        <= i_operation;
                    r_t         <= AW'(i_task_req);
                    r_prio_in   <= i_priority_req;
                    r_slice_in  <= i_initial_slice;
                    r_chosen    <= '0;
                    r_cvalid    <= 1'b0;
                    r_refilled  <= 1'b0;
                    r_rsched    <= 1'b0;
                    r_slice_out <= '0;
                    r_idx       <= '0;
                    r_found     <= 1'b0;
                    r_mode      <= SW_SCAN;
                end
            end
            ST_CHECK: begin
                r_idx   <= '0;
                r_rec_t <= rd.recency;
                case (r_op)
                    OP_DEFINE: r_slice_out <= r_slice_in;
                    OP_TICK: begin
                        r_slice_out <= tick_cnt;
                        r_rsched    <= (rd.counter <= 9'd1);
                    end
                    OP_ENQUEUE: begin
                        r_slice_out <= rd.counter;
                        r_mode      <= SW_ENQ;
                    end
                    OP_DEQUEUE: begin
                        r_slice_out <= rd.counter;
                        r_mode      <= SW_DEQ;
                    end
                    default: r_slice_out <= '0;
                endcase
            end
            ST_SWEEP: begin
                if (r_idx != IDX_END) begin
                    r_idx  <= r_idx + CW'(1);
                    r_pidx <= r_idx[AW-1:0];
                end
                if ((r_mode == SW_SCAN) && r_pv) begin
                    r_found    <= scan_found;
                    r_best_idx <= scan_idx;
                    r_best_cnt <= scan_cnt;
                    r_best_rec <= scan_rec;
                end
                if (sweep_end) begin
                    r_idx <= '0;
                    if (refill_go) begin
                        r_mode     <= SW_REFILL;
                        r_refilled <= 1'b1;
                    end else if (r_mode == SW_REFILL) begin
                        r_mode  <= SW_SCAN;
                        r_found <= 1'b0;
                    end else if (r_mode == SW_SCAN) begin
                        r_chosen    <= scan_found ? 4'(scan_idx) : 4'd0;
                        r_cvalid    <= scan_found;
                        r_slice_out <= scan_found ? scan_cnt : 9'd0;
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_chosen_task  = r_chosen;
    assign o_chosen_valid = r_cvalid;
    assign o_refilled     = r_refilled;
    assign o_resched      = r_rsched;
    assign o_slice_now    = r_slice_out;
    assign o_queued_count = r_qtotal;

    `CTSU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `CTSU_ASSERT_NEXT(a_done_pulse, o_done, !o_done && !busy, "result strobe longer than one cycle")
    `CTSU_ASSERT(a_valid_on_pick, (o_done && o_chosen_valid) |-> (r_op == OP_PICK), "choice without pick")
    `CTSU_ASSERT(a_sweep_no_overlap, (r_state == ST_SWEEP && mem_we) |-> (mem_waddr != mem_raddr), "sweep write hits read slot")
    `CTSU_ASSERT(a_qtotal_range, {2'b00, r_qtotal} <= 7'(MAX_TASKS), "queued count out of range")

endmodule

### sim/counter_time_slice_scheduler_unit_test.sv
module counter_time_slice_scheduler_unit_test;
    import ctsu_pkg::*;

    localparam int SLOTS          = 16;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 110;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int REPORT_LIMIT   = 10;

    // Operation codes the block treats as no-ops.
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [3:0] chosen;
        logic       valid;
        logic       refilled;
        logic       resched;
        logic [8:0] slice;
        logic [4:0] count;
    } t_decision;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CFG
    } t_row_kind;

    // For ROW_CFG rows the prio column carries the base slice value.
    typedef struct packed {
        t_row_kind  kind;
        logic [2:0] op;
        logic [3:0] slot;
        logic [7:0] prio;
        logic [8:0] slice;
        t_decision  want;
    } t_step_row;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       start           = 1'b0;
    logic [2:0] i_operation     = '0;
    logic [3:0] i_task_req      = '0;
    logic [7:0] i_priority_req  = '0;
    logic [8:0] i_initial_slice = '0;
    logic       i_cfg_we        = 1'b0;
    logic [7:0] i_cfg_wdata     = '0;
    logic       busy;
    logic       o_done;
    logic [3:0] o_chosen_task;
    logic       o_chosen_valid;
    logic       o_refilled;
    logic       o_resched;
    logic [8:0] o_slice_now;
    logic [4:0] o_queued_count;

    // Scheduler image kept by the testbench.
    logic       slot_queued  [SLOTS];
    logic [8:0] slot_counter [SLOTS];
    logic [7:0] slot_prio    [SLOTS];
    logic [3:0] slot_rank    [SLOTS];
    logic [4:0] queued_total;
    logic [7:0] base_slice;

    t_decision  pending_decisions [$];
    int         mismatch_count = 0;
    int         idle_cycles    = 0;
    logic [3:0] running_slot   = '0;

    t_step_row directed_rows [28] = '{
        '{ROW_TYPED,   OP_PICK,    0,   0,   0, '{0, 0, 0, 0,   0, 0}},
        '{ROW_TYPED,   OP_RSVD5,   3, 255, 511, '{0, 0, 0, 0,   0, 0}},
        '{ROW_TYPED,   OP_RSVD7,  15,   0,   0, '{0, 0, 0, 0,   0, 0}},
        '{ROW_TYPED,   OP_TICK,    2,   0,   0, '{0, 0, 0, 1,   0, 0}},
        '{ROW_TYPED,   OP_DEFINE,  0, 255, 511, '{0, 0, 0, 0, 511, 0}},
        '{ROW_TYPED,   OP_DEFINE, 15,   0,   0, '{0, 0, 0, 0,   0, 0}},
        '{ROW_TYPED,   OP_ENQUEUE,15,   0,   0, '{0, 0, 0, 0,   0, 1}},
        '{ROW_TYPED,   OP_ENQUEUE,15,   0,   0, '{0, 0, 0, 0,   0, 1}},
        '{ROW_TYPED,   OP_ENQUEUE, 0,   0,   0, '{0, 0, 0, 0, 511, 2}},
        '{ROW_TYPED,   OP_PICK,    0,   0,   0, '{0, 1, 0, 0, 511, 2}},
        '{ROW_TYPED,   OP_DEQUEUE, 0,   0,   0, '{0, 0, 0, 0, 511, 1}},
        '{ROW_TYPED,   OP_DEQUEUE, 0,   0,   0, '{0, 0, 0, 0, 511, 1}},
        '{ROW_PREDICT, OP_PICK,    0,   0,   0, '0},
        '{ROW_PREDICT, OP_DEFINE, 15,   0,   1, '0},
        '{ROW_TYPED,   OP_TICK,   15,   0,   0, '{0, 0, 0, 1,   0, 1}},
        '{ROW_PREDICT, OP_DEFINE,  7, 100,   3, '0},
        '{ROW_PREDICT, OP_ENQUEUE, 7,   0,   0, '0},
        '{ROW_PREDICT, OP_DEFINE,  3,   0,   3, '0},
        '{ROW_PREDICT, OP_ENQUEUE, 3,   0,   0, '0},
        '{ROW_PREDICT, OP_PICK,    0,   0,   0, '0},   // tie goes to slot 3
        '{ROW_CFG,     OP_DEFINE,  0,   0,   0, '0},
        '{ROW_PREDICT, OP_DEFINE,  3,   0,   0, '0},
        '{ROW_PREDICT, OP_DEFINE,  7,   0,   0, '0},
        '{ROW_PREDICT, OP_PICK,    0,   0,   0, '0},   // refill leaves zero
        '{ROW_CFG,     OP_DEFINE,  0, 255,   0, '0},
        '{ROW_PREDICT, OP_DEFINE,  7, 255,   0, '0},
        '{ROW_TYPED,   OP_PICK,    0,   0,   0, '{7, 1, 1, 0, 510, 3}},
        '{ROW_TYPED,   OP_RSVD6,   0,   0,   0, '{0, 0, 0, 0,   0, 3}}
    };

    counter_time_slice_scheduler_unit #(
        .MAX_TASKS (SLOTS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .o_done          (o_done),
        .i_operation     (i_operation),
        .i_task_req      (i_task_req),
        .i_priority_req  (i_priority_req),
        .i_initial_slice (i_initial_slice),
        .o_chosen_task   (o_chosen_task),
        .o_chosen_valid  (o_chosen_valid),
        .o_refilled      (o_refilled),
        .o_resched       (o_resched),
        .o_slice_now     (o_slice_now),
        .o_queued_count  (o_queued_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Largest counter among queued slots, ties to the lowest rank (most recent).
    function automatic int best_slot();
        int best;
        int i;
        best = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_queued[i] && (best < 0 || slot_counter[i] > slot_counter[best] ||
                (slot_counter[i] == slot_counter[best] && slot_rank[i] < slot_rank[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic t_decision schedule_op(input logic [2:0] op, input logic [3:0] slot,
                                              input logic [7:0] prio, input logic [8:0] slice);
        t_decision d;
        int        best;
        int        i;
        d = '0;
        case (op)
            OP_DEFINE: begin
                slot_prio[slot]    = prio;
                slot_counter[slot] = slice;
            end
            OP_ENQUEUE: begin
                if (!slot_queued[slot]) begin
                    for (i = 0; i < SLOTS; i++)
                        if (slot_queued[i]) slot_rank[i] = slot_rank[i] + 1'b1;
                    slot_rank[slot]   = '0;
                    slot_queued[slot] = 1'b1;
                    queued_total      = queued_total + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (slot_queued[slot]) begin
                    for (i = 0; i < SLOTS; i++)
                        if (slot_queued[i] && slot_rank[i] > slot_rank[slot])
                            slot_rank[i] = slot_rank[i] - 1'b1;
                    slot_queued[slot] = 1'b0;
                    slot_rank[slot]   = '0;
                    queued_total      = queued_total - 1'b1;
                end
            end
            OP_TICK: begin
                if (slot_counter[slot] <= 9'd1) begin
                    slot_counter[slot] = '0;
                    d.resched          = 1'b1;
                end else begin
                    slot_counter[slot] = slot_counter[slot] - 1'b1;
                end
            end
            OP_PICK: begin
                best = best_slot();
                if (best >= 0 && slot_counter[best] == '0) begin
                    // every spent slot is refilled, queued or not
                    for (i = 0; i < SLOTS; i++)
                        if (slot_counter[i] == '0) slot_counter[i] = base_slice + slot_prio[i];
                    d.refilled = 1'b1;
                    best       = best_slot();
                end
                if (best >= 0) begin
                    d.chosen = 4'(best);
                    d.valid  = 1'b1;
                    d.slice  = slot_counter[best];
                end
            end
            default: ;
        endcase
        if (op < OP_PICK) d.slice = slot_counter[slot];
        d.count = queued_total;
        return d;
    endfunction

    function automatic int sender_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_step_row random_row(input logic [3:0] hot_slot);
        t_step_row row;
        int        roll;
        row      = '0;
        row.kind = ROW_PREDICT;
        row.slot = 4'($urandom_range(0, SLOTS - 1));
        row.prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
        row.slice = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 6))
                                               : 9'($urandom_range(0, 511));
        roll = $urandom_range(0, 99);
        if (roll < 18) begin
            row.op = OP_DEFINE;
        end else if (roll < 38) begin
            row.op = OP_ENQUEUE;
        end else if (roll < 52) begin
            row.op = OP_DEQUEUE;
        end else if (roll < 80) begin
            // mostly charge the tick to the task that was last picked
            row.op = OP_TICK;
            if ($urandom_range(0, 3) != 0) row.slot = hot_slot;
        end else if (roll < 96) begin
            row.op = OP_PICK;
        end else begin
            case ($urandom_range(0, 2))
                0:       row.op = OP_RSVD5;
                1:       row.op = OP_RSVD6;
                default: row.op = OP_RSVD7;
            endcase
        end
        return row;
    endfunction

    task automatic send_item(input t_step_row row, output t_decision predicted);
        i_operation     <= row.op;
        i_task_req      <= row.slot;
        i_priority_req  <= row.prio;
        i_initial_slice <= row.slice;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = schedule_op(row.op, row.slot, row.prio, row.slice);
        pending_decisions.push_back(row.kind == ROW_TYPED ? row.want : predicted);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_decisions.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_base(input logic [7:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        base_slice = value;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic log_mismatch(input string what, input t_decision want, input t_decision seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t %s: expected task %0d valid %0b refill %0b resched %0b slice %0d queued %0d",
                     $time, what, want.chosen, want.valid, want.refilled, want.resched,
                     want.slice, want.count);
            $display("%0t %s: got task %0d valid %0b refill %0b resched %0b slice %0d queued %0d",
                     $time, what, seen.chosen, seen.valid, seen.refilled, seen.resched,
                     seen.slice, seen.count);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_decision seen;
        t_decision want;
        if (i_rst_n && o_done === 1'b1) begin
            seen = '{o_chosen_task, o_chosen_valid, o_refilled, o_resched, o_slice_now,
                     o_queued_count};
            if (pending_decisions.size() == 0) begin
                log_mismatch("result with nothing pending", '0, seen);
            end else begin
                want = pending_decisions.pop_front();
                if (seen !== want) log_mismatch("result differs", want, seen);
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_done === 1'b1 || (start && busy === 1'b0)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_decision  last;
        logic [7:0] phase_base [PHASES];
        int         phase;
        int         n;
        int         r;
        for (r = 0; r < SLOTS; r++) begin
            slot_queued[r]  = 1'b0;
            slot_counter[r] = '0;
            slot_prio[r]    = '0;
            slot_rank[r]    = '0;
        end
        queued_total = '0;
        base_slice   = BASE_SLICE_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < $size(directed_rows); r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_base(directed_rows[r].prio);
            end else begin
                send_item(directed_rows[r], last);
                hold_off(sender_gap(1'b0));
            end
        end

        phase_base[0] = 8'd1;
        phase_base[1] = 8'd255;
        for (phase = 2; phase < PHASES; phase++) phase_base[phase] = 8'($urandom_range(1, 254));

        for (phase = 0; phase < PHASES; phase++) begin
            write_base(phase_base[phase]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_row(running_slot), last);
                if (last.valid) running_slot = last.chosen;
                // phase 2 runs back to back
                if ($urandom_range(0, 49) == 0) drain();
                else hold_off(sender_gap(phase == 2));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_decisions.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
